>>> hdl/qpsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position/speed/accel package
// Shared widths, command codes, control structs and the saturation helper.
// ----------------------------------------------------------------------------
package qpsa_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned ScaleW        = 16;
  localparam int unsigned OperandW      = DataW + 1;
  localparam int unsigned ProdW         = OperandW + ScaleW + 1;
  localparam int unsigned PositionDepth = 8;
  localparam int unsigned SpeedDepth    = 8;

  // Input command codes.
  localparam logic [1:0] CMD_RISE = 2'd0;
  localparam logic [1:0] CMD_FALL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic REG_FORWARD    = 1'b0;
  localparam logic REG_RATE_SCALE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic edge_step;  // move the count by one step
    logic edge_rise;  // the step comes from a rising B edge
    logic mul_pos;    // multiply the position difference, write position ring
    logic sat_pos;    // saturate the product into the speed register
    logic mul_spd;    // multiply the speed difference, write speed ring
    logic sat_spd;    // saturate the product into the acceleration register
    logic load_out;   // update the sign flags and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // the result register can take a new transaction
  } dp_stat_t;

  // Clamp a product to the signed 32-bit range.
  function automatic logic [DataW-1:0] sat32(input logic signed [ProdW-1:0] p);
    logic [DataW-1:0] r;
    if (!p[ProdW-1] && (|p[ProdW-2:DataW-1])) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (p[ProdW-1] && !(&p[ProdW-2:DataW-1])) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = p[DataW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/quadrature_position_speed_accel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position, speed and acceleration unit
// x2 quadrature decoder with ring-history speed and acceleration estimates.
// ----------------------------------------------------------------------------
// Each input transaction is a rising or falling B edge (with the sampled A
// level) or a speed tick, and each one yields exactly one result transaction
// carrying the position, the last speed, the last acceleration and a sticky
// flag that is set once the position has been both positive and negative.
// An edge or an unused command is accepted in the idle state, where an edge
// also steps the counter, and the done state then updates the sign flags and
// loads the result once the result register is free. A tick runs through
// multiply and saturate states, as one shared 33x17 multiplier is used twice
// in sequence: the position difference against the ring entry POSITION_DEPTH
// ticks old is scaled by rate_scale and saturated into the speed, then the
// speed difference against the entry SPEED_DEPTH ticks old is scaled and
// saturated into the acceleration. One transaction is in work at a time; a
// new one is accepted as soon as the previous result sits in the output
// register, even while that result waits to be taken. The history rings
// reset to zero through per-entry valid bits, so no clearing pass is needed.
// Configuration goes through an APB-style port: forward at address 0 and
// rate_scale at address 4. Position wraps two's complement; speed and
// acceleration saturate to the signed 32-bit range.
// ----------------------------------------------------------------------------
module quadrature_position_speed_accel_unit
  import qpsa_pkg::*;
#(
  parameter int unsigned POSITION_DEPTH = PositionDepth,
  parameter int unsigned SPEED_DEPTH    = SpeedDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB-style configuration port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel.
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic             a_level_i,
  // Result channel.
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] position_o,
  output logic [DataW-1:0] speed_o,
  output logic [DataW-1:0] accel_o,
  output logic             both_signs_seen_o
);

  logic              forward_q;
  logic [ScaleW-1:0] rate_scale_q;
  logic              reg_index;
  logic              cfg_write;
  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;

  // Register index is the word address; the port never stalls.
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_q    <= 1'b1;
      rate_scale_q <= ScaleW'(100);
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_FORWARD:    forward_q    <= pwdata[0];
        REG_RATE_SCALE: rate_scale_q <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_FORWARD:    prdata = {31'b0, forward_q};
      REG_RATE_SCALE: prdata = {16'b0, rate_scale_q};
      default:        prdata = '0;
    endcase
  end

  // The controller sequences each transaction; the datapath holds the count, history and result state.
  qpsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .dp_cmd_o   (dp_cmd)
  );

  qpsa_datapath #(
    .POSITION_DEPTH (POSITION_DEPTH),
    .SPEED_DEPTH    (SPEED_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .forward_i         (forward_q),
    .rate_scale_i      (rate_scale_q),
    .a_level_i         (a_level_i),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .position_o        (position_o),
    .speed_o           (speed_o),
    .accel_o           (accel_o),
    .both_signs_seen_o (both_signs_seen_o)
  );

endmodule

>>> hdl/qpsa_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// History ring
// A circular history memory with a write slot, per-entry valid bits and a
// registered read of the entry under the slot; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module qpsa_ring
  import qpsa_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [DataW-1:0] wr_data_i,
  output logic [DataW-1:0] rd_data_o
);

  localparam int unsigned SlotW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(DEPTH - 1);

  logic [DataW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q, valid_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [DataW-1:0] rd_q;
  logic             rd_valid_q;

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    if (wr_en_i) begin
      valid_d[slot_q] = 1'b1;
      slot_d = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      slot_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      slot_q     <= slot_d;
      rd_valid_q <= valid_q[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[slot_q] <= wr_data_i;
    end
    rd_q <= mem[slot_q];
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

>>> hdl/qpsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature datapath
// Edge counter, position and speed rings, shared scale multiplier,
// saturation, sign flags and the result register.
// ----------------------------------------------------------------------------
module qpsa_datapath
  import qpsa_pkg::*;
#(
  parameter int unsigned POSITION_DEPTH = PositionDepth,
  parameter int unsigned SPEED_DEPTH    = SpeedDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              forward_i,
  input  logic [ScaleW-1:0] rate_scale_i,
  input  logic              a_level_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DataW-1:0]  position_o,
  output logic [DataW-1:0]  speed_o,
  output logic [DataW-1:0]  accel_o,
  output logic              both_signs_seen_o
);

  logic [DataW-1:0] count_q, count_d;
  logic [DataW-1:0] speed_q, accel_q;
  logic [DataW-1:0] old_pos, old_spd;
  logic signed [ProdW-1:0] prod_q;
  logic signed [OperandW-1:0] operand;
  logic signed [ScaleW:0] scale;
  logic [DataW-1:0] pos_diff;
  logic plus_q, minus_q, plus_d, minus_d;
  logic out_valid_q;
  logic [DataW-1:0] pos_out_q, spd_out_q, acc_out_q;
  logic both_out_q;
  logic up;

  qpsa_ring #(.DEPTH(POSITION_DEPTH)) u_pos_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_i.mul_pos),
    .wr_data_i (count_q),
    .rd_data_o (old_pos)
  );

  qpsa_ring #(.DEPTH(SPEED_DEPTH)) u_spd_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_i.mul_spd),
    .wr_data_i (speed_q),
    .rd_data_o (old_spd)
  );

  // Direction of one step: A level, inverted when rise and the forward
  // setting disagree.
  assign up      = (cmd_i.edge_rise ^ ~forward_i) ? a_level_i : ~a_level_i;
  assign count_d = up ? count_q + 1'b1 : count_q - 1'b1;

  assign pos_diff = count_q - old_pos;
  assign scale    = $signed({1'b0, rate_scale_i});

  always_comb begin
    if (cmd_i.mul_pos) begin
      operand = $signed({pos_diff[DataW-1], pos_diff});
    end else begin
      operand = $signed({speed_q[DataW-1], speed_q})
              - $signed({old_spd[DataW-1], old_spd});
    end
  end

  // Sticky sign flags, evaluated on the count as it stands at result time.
  assign plus_d  = plus_q  | (!count_q[DataW-1] && (|count_q));
  assign minus_d = minus_q | count_q[DataW-1];

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(operand * scale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      speed_q     <= '0;
      accel_q     <= '0;
      plus_q      <= 1'b0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.edge_step) begin
        count_q <= count_d;
      end
      if (cmd_i.sat_pos) begin
        speed_q <= sat32(prod_q);
      end
      if (cmd_i.sat_spd) begin
        accel_q <= sat32(prod_q);
      end
      if (cmd_i.load_out) begin
        plus_q      <= plus_d;
        minus_q     <= minus_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pos_out_q  <= count_q;
      spd_out_q  <= speed_q;
      acc_out_q  <= accel_q;
      both_out_q <= plus_d & minus_d;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign position_o        = pos_out_q;
  assign speed_o           = spd_out_q;
  assign accel_o           = acc_out_q;
  assign both_signs_seen_o = both_out_q;

endmodule

>>> hdl/qpsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature controller
// Sequences edge steps and the two multiply/saturate passes of a speed tick.
// ----------------------------------------------------------------------------
module qpsa_ctrl
  import qpsa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    dp_cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_POS,
    ST_SAT_POS,
    ST_MUL_SPD,
    ST_SAT_SPD,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (cmd_i == CMD_TICK) ? ST_MUL_POS : ST_DONE;
          end
        end
        ST_MUL_POS: state_q <= ST_SAT_POS;
        ST_SAT_POS: state_q <= ST_MUL_SPD;
        ST_MUL_SPD: state_q <= ST_SAT_SPD;
        ST_SAT_SPD: state_q <= ST_DONE;
        ST_DONE: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    dp_cmd_o           = '0;
    dp_cmd_o.edge_rise = (cmd_i == CMD_RISE);
    dp_cmd_o.edge_step = accept && ((cmd_i == CMD_RISE) || (cmd_i == CMD_FALL));
    dp_cmd_o.mul_pos   = (state_q == ST_MUL_POS);
    dp_cmd_o.sat_pos   = (state_q == ST_SAT_POS);
    dp_cmd_o.mul_spd   = (state_q == ST_MUL_SPD);
    dp_cmd_o.sat_spd   = (state_q == ST_SAT_SPD);
    dp_cmd_o.load_out  = (state_q == ST_DONE) && stat_i.out_free;
  end

endmodule
